FILE: sv/crv_pkg.sv
// ----------------------------------------------------------------------------
// crv_pkg
// Shared types and constants for the curve point evaluator: payload structs,
// the command passed from the front to the back, and fixed-point widths.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int COORD_BITS  = 32;
  localparam int MAX_POINTS  = 64;
  localparam int ADDR_BITS   = 6;
  localparam int CNT_BITS    = 7;
  localparam int KIND_BITS   = 2;
  localparam int T_BITS      = 17;
  localparam int U_BITS      = 17;
  localparam int SEG_S_BITS  = 23;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 7;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Q1.16 value of 1.0
  localparam logic [T_BITS-1:0] T_ONE = T_BITS'(65536);

  typedef enum logic {MODE_LOAD, MODE_EVAL} crv_mode_t;
  typedef enum logic {STATUS_DONE, STATUS_RANGE} crv_status_t;
  typedef enum logic [CFG_IDX_BITS-1:0] {CFG_CURVE_KIND, CFG_POINT_COUNT} crv_cfg_idx_t;
  typedef enum logic [KIND_BITS-1:0] {KIND_LINEAR, KIND_CATMULL, KIND_BSPLINE} crv_kind_t;

  typedef enum logic [2:0] {OP_LOAD, OP_BAD, OP_ZERO, OP_ONE, OP_CURVE} crv_op_t;
  typedef enum logic [1:0] {BAS_LIN, BAS_CR, BAS_BS} crv_basis_t;

  // back-end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_ONE, ST_SQ, ST_CUBE, ST_U3, ST_BASIS, ST_RECIP, ST_RTAKE,
    ST_READ, ST_MAC, ST_DRAIN, ST_ROUND, ST_DIVINIT, ST_DIV, ST_DIVDONE,
    ST_SAT, ST_PUSH
  } crv_state_t;

  typedef struct packed {
    logic                         mode;
    logic [ADDR_BITS-1:0]         point_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic signed [COORD_BITS-1:0] coord_z;
    logic signed [COORD_BITS-1:0] point_weight;
    logic [T_BITS-1:0]            param_t;
  } crv_in_t;

  typedef struct packed {
    logic                         status;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
  } crv_res_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic signed [COORD_BITS-1:0] w;
  } crv_point_t;

  typedef struct packed {
    crv_op_t                   op;
    crv_basis_t                basis;
    logic [3:0][ADDR_BITS-1:0] addr;
    logic [U_BITS-1:0]         u;
    crv_point_t                pt;
  } crv_cmd_t;

endpackage

FILE: sv/curve_point_evaluator.sv
// ----------------------------------------------------------------------------
// curve_point_evaluator
// Weighted 3D control point table with linear, Catmull-Rom and rational
// B-spline evaluation in Q16.16 fixed point.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   input    | push / full        | in_data  (crv_in_t)
//   result   | pop / empty        | out_data (crv_res_t), one per item
//   config   | cfg_we, no wait    | cfg_index, cfg_data
//
// Loads, out-of-range loads and empty-table evaluations go straight to the
// result; a single-point evaluation first reads the table. A curve evaluation
// runs the shared multiplier through basis forming and 8 (linear) or 16 blend
// products; the B-spline then runs its 33-step divider (skipped when the
// blended weight is zero). Synchronous active-low reset;
// the table holds no reset value.
// A two-entry command queue and a two-entry result queue let either side
// stall without stopping the other.
// ----------------------------------------------------------------------------
module curve_point_evaluator import crv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  crv_in_t                  in_data,
  input  logic                     push,
  output logic                     full,
  output crv_res_t                 out_data,
  output logic                     empty,
  input  logic                     pop
);

  crv_cmd_t cmd_data;
  crv_res_t res_data;
  logic     cmd_pop, cmd_empty, res_push, res_full;

  crv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .in_push   (push),
    .in_full   (full),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .cmd_empty (cmd_empty)
  );

  crv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_data  (cmd_data),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_data  (res_data),
    .res_full  (res_full),
    .res_push  (res_push)
  );

  crv_fifo #(
    .WIDTH ($bits(crv_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

FILE: sv/crv_fifo.sv
// ----------------------------------------------------------------------------
// crv_fifo
// Small register queue with full/empty flags; read data shows the oldest entry.
// ----------------------------------------------------------------------------
module crv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: sv/crv_front.sv
// ----------------------------------------------------------------------------
// crv_front
// Holds the configuration registers, classifies each incoming transaction,
// works out segment, local parameter and neighbor slots, and queues the
// resulting command for the back end.
// ----------------------------------------------------------------------------
module crv_front import crv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  crv_in_t                  in_data,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     cmd_pop,
  output crv_cmd_t                 cmd_data,
  output logic                     cmd_empty
);

  logic [KIND_BITS-1:0]  kind_r;
  logic [CNT_BITS-1:0]   count_r;
  logic [CNT_BITS-1:0]   n, nm1, nm2;
  logic [T_BITS-1:0]     tc;
  logic [SEG_S_BITS-1:0] s;
  logic [CNT_BITS-1:0]   seg_raw;
  logic [ADDR_BITS-1:0]  seg, a2;
  crv_cmd_t              cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (crv_cfg_idx_t'(cfg_index))
        CFG_CURVE_KIND:  kind_r  <= cfg_data[KIND_BITS-1:0];
        CFG_POINT_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n   = (count_r > CNT_BITS'(MAX_POINTS)) ? CNT_BITS'(MAX_POINTS) : count_r;
    nm1 = n - CNT_BITS'(1);
    nm2 = n - CNT_BITS'(2);
    tc  = (in_data.param_t > T_ONE) ? T_ONE : in_data.param_t;
    s   = SEG_S_BITS'(tc) * SEG_S_BITS'(nm1[ADDR_BITS-1:0]);
    seg_raw = s[SEG_S_BITS-1:16];
    seg = (seg_raw > nm2) ? nm2[ADDR_BITS-1:0] : seg_raw[ADDR_BITS-1:0];
    a2  = seg + ADDR_BITS'(1);

    cmd.pt.x  = in_data.coord_x;
    cmd.pt.y  = in_data.coord_y;
    cmd.pt.z  = in_data.coord_z;
    cmd.pt.w  = in_data.point_weight;
    cmd.u     = U_BITS'(s - SEG_S_BITS'({seg, 16'h0000}));
    cmd.addr[1] = seg;
    cmd.addr[2] = a2;
    cmd.addr[0] = (seg == '0) ? seg : seg - ADDR_BITS'(1);
    cmd.addr[3] = ({1'b0, a2} >= nm1) ? a2 : a2 + ADDR_BITS'(1);

    if (kind_r == KIND_LINEAR || n == CNT_BITS'(2)) begin
      cmd.basis = BAS_LIN;
    end else if (kind_r == KIND_CATMULL) begin
      cmd.basis = BAS_CR;
    end else begin
      cmd.basis = BAS_BS;
    end

    if (in_data.mode == MODE_LOAD) begin
      cmd.op      = ({1'b0, in_data.point_index} < n) ? OP_LOAD : OP_BAD;
      cmd.addr[0] = in_data.point_index;
    end else if (n == '0) begin
      cmd.op = OP_ZERO;
    end else if (n == CNT_BITS'(1)) begin
      cmd.op = OP_ONE;
    end else begin
      cmd.op = OP_CURVE;
    end
  end

  crv_fifo #(
    .WIDTH ($bits(crv_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd_data),
    .empty (cmd_empty)
  );

endmodule

FILE: sv/crv_back.sv
// ----------------------------------------------------------------------------
// crv_back
// Executes commands: owns the point table, forms basis weights, blends up to
// four neighbors with one shared multiplier, and for the B-spline divides by
// the blended weight with three radix-2 divider lanes.
// ----------------------------------------------------------------------------
module crv_back import crv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  crv_cmd_t cmd_data,
  input  logic     cmd_empty,
  output logic     cmd_pop,
  output crv_res_t res_data,
  input  logic     res_full,
  output logic     res_push
);

  localparam int BASIS_BITS = 18;
  localparam int A_BITS     = 19;
  localparam int ACC_BITS   = 52;
  localparam int RES_BITS   = 37;
  localparam int NUM_BITS   = 53;
  localparam int MULA_BITS  = 34;
  localparam int MULB_BITS  = 23;
  localparam int PROD_BITS  = MULA_BITS + MULB_BITS;
  localparam int U2_BITS    = 33;
  localparam int U3_BITS    = 49;
  localparam int AD_BITS    = 37;
  localparam int NP_BITS    = 54;
  localparam int Q_BITS     = 33;
  localparam int REM_BITS   = 38;
  localparam int DCNT_BITS  = 6;

  localparam logic signed [NUM_BITS-1:0]  NUM_ONE  = NUM_BITS'(1) << 48;
  localparam logic signed [NUM_BITS-1:0]  CR_HALF  = NUM_BITS'(1) << 32;
  localparam logic signed [NUM_BITS-1:0]  BS_BIAS  = NUM_BITS'(3) << 32;
  localparam logic signed [ACC_BITS-1:0]  ACC_HALF = ACC_BITS'(1) << 15;
  localparam logic signed [MULB_BITS-1:0] RECIP6   = MULB_BITS'(2796203);
  localparam logic signed [RES_BITS-1:0]  RES_BIG  = RES_BITS'(1) << 35;
  localparam logic signed [RES_BITS-1:0]  SAT_MAX  = RES_BITS'(2147483647);
  localparam logic signed [RES_BITS-1:0]  SAT_MIN  = -SAT_MAX - RES_BITS'(1);
  localparam logic [DCNT_BITS-1:0]        DIV_LAST = DCNT_BITS'(Q_BITS - 1);

  crv_state_t state_r, state_nxt;
  crv_cmd_t   cmd_r;
  crv_res_t   out_r;
  crv_point_t mem [MAX_POINTS];
  crv_point_t rd_r;

  logic [1:0]                    k_r, c_r, mac_c_r, k_last;
  logic                          mac_v_r;
  logic [DCNT_BITS-1:0]          dcnt_r;
  logic [U2_BITS-1:0]            u2_r;
  logic [U3_BITS-1:0]            u3_r;
  logic [A_BITS-1:0]             a_r;
  logic signed [BASIS_BITS-1:0]  b_r   [4];
  logic signed [ACC_BITS-1:0]    acc_r [4];
  logic signed [RES_BITS-1:0]    res_r [4];
  logic signed [PROD_BITS-1:0]   prod, prod_r;
  logic signed [MULA_BITS-1:0]   mul_a;
  logic signed [MULB_BITS-1:0]   mul_b;

  logic                          mem_we, rd_en;
  logic [ADDR_BITS-1:0]          rd_addr;

  logic signed [NUM_BITS-1:0]    big_u, big_u2, cu3, num, cr_sum, bs_sum;
  logic signed [COORD_BITS-1:0]  csel;
  logic signed [ACC_BITS-1:0]    rnd_sum [4];
  logic signed [RES_BITS-1:0]    rnd     [4];
  logic signed [RES_BITS-1:0]    sat_v   [3];

  logic [AD_BITS-1:0]            ad_r, ad;
  logic                          w_neg;
  logic [REM_BITS-1:0]           rem_r [3];
  logic [Q_BITS-1:0]             lo_r  [3];
  logic [Q_BITS-1:0]             q_r   [3];
  logic                          ovf_r [3];
  logic                          neg_r [3];
  logic [NP_BITS-1:0]            np    [3];
  logic [AD_BITS-1:0]            an    [3];
  logic [REM_BITS-1:0]           trial [3];

  assign k_last   = (cmd_r.basis == BAS_LIN) ? 2'd2 : 2'd3;
  assign res_data = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd_data.op) inside
            OP_LOAD, OP_BAD, OP_ZERO: state_nxt = ST_PUSH;
            OP_ONE:                   state_nxt = ST_ONE;
            default: state_nxt = (cmd_data.basis == BAS_LIN) ? ST_READ : ST_SQ;
          endcase
        end
      end
      ST_ONE:   state_nxt = ST_PUSH;
      ST_SQ:    state_nxt = ST_CUBE;
      ST_CUBE:  state_nxt = ST_U3;
      ST_U3:    state_nxt = ST_BASIS;
      ST_BASIS: begin
        if (cmd_r.basis == BAS_BS) begin
          state_nxt = ST_RECIP;
        end else if (k_r == 2'd3) begin
          state_nxt = ST_READ;
        end
      end
      ST_RECIP: state_nxt = ST_RTAKE;
      ST_RTAKE: state_nxt = (k_r == 2'd3) ? ST_READ : ST_BASIS;
      ST_READ:  state_nxt = ST_MAC;
      ST_MAC: begin
        if (c_r == 2'd3) begin
          state_nxt = (k_r == k_last) ? ST_DRAIN : ST_READ;
        end
      end
      ST_DRAIN: state_nxt = ST_ROUND;
      ST_ROUND: begin
        state_nxt = (cmd_r.basis == BAS_BS && rnd[3] != '0) ? ST_DIVINIT : ST_SAT;
      end
      ST_DIVINIT: state_nxt = ST_DIV;
      ST_DIV:     state_nxt = (dcnt_r == '0) ? ST_DIVDONE : ST_DIV;
      ST_DIVDONE: state_nxt = ST_SAT;
      ST_SAT:     state_nxt = ST_PUSH;
      ST_PUSH:    state_nxt = res_full ? ST_PUSH : ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop  = (state_r == ST_IDLE) && !cmd_empty;
    mem_we   = cmd_pop && (cmd_data.op == OP_LOAD);
    rd_en    = (state_r == ST_READ) || (cmd_pop && cmd_data.op == OP_ONE);
    rd_addr  = (state_r == ST_READ) ? cmd_r.addr[k_r] : '0;
    res_push = (state_r == ST_PUSH) && !res_full;
  end

  // shared multiplier operands
  always_comb begin
    case (c_r)
      2'd0:    csel = rd_r.x;
      2'd1:    csel = rd_r.y;
      2'd2:    csel = rd_r.z;
      default: csel = rd_r.w;
    endcase
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ: begin
        mul_a = signed'(MULA_BITS'(cmd_r.u));
        mul_b = signed'(MULB_BITS'(cmd_r.u));
      end
      ST_CUBE: begin
        mul_a = signed'(MULA_BITS'(prod_r[U2_BITS-1:0]));
        mul_b = signed'(MULB_BITS'(cmd_r.u));
      end
      ST_RECIP: begin
        mul_a = signed'(MULA_BITS'(a_r));
        mul_b = RECIP6;
      end
      ST_MAC: begin
        mul_a = MULA_BITS'(csel);
        mul_b = MULB_BITS'(b_r[k_r]);
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  // basis numerators, Q48
  always_comb begin
    big_u  = signed'(NUM_BITS'({cmd_r.u, 32'h0000_0000}));
    big_u2 = signed'(NUM_BITS'({u2_r, 16'h0000}));
    cu3    = signed'(NUM_BITS'(u3_r));
    if (cmd_r.basis == BAS_CR) begin
      case (k_r)
        2'd0:    num = -cu3 + (big_u2 <<< 1) - big_u;
        2'd1:    num = 3 * cu3 - 5 * big_u2 + (NUM_ONE <<< 1);
        2'd2:    num = -3 * cu3 + 4 * big_u2 + big_u;
        default: num = cu3 - big_u2;
      endcase
    end else begin
      case (k_r)
        2'd0:    num = NUM_ONE - 3 * big_u + 3 * big_u2 - cu3;
        2'd1:    num = 3 * cu3 - 6 * big_u2 + 4 * NUM_ONE;
        2'd2:    num = -3 * cu3 + 3 * big_u2 + 3 * big_u + NUM_ONE;
        default: num = cu3;
      endcase
    end
    cr_sum = num + CR_HALF;
    bs_sum = num + BS_BIAS;
  end

  // rounding of the accumulators, divider setup and saturation
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rnd_sum[i] = acc_r[i] + ACC_HALF;
      rnd[i]     = RES_BITS'($signed(rnd_sum[i][ACC_BITS-1:16]));
    end
    w_neg = res_r[3] < 0;
    ad    = AD_BITS'(w_neg ? -res_r[3] : res_r[3]);
    for (int i = 0; i < 3; i++) begin
      an[i]    = AD_BITS'((res_r[i] < 0) ? -res_r[i] : res_r[i]);
      np[i]    = NP_BITS'({an[i], 16'h0000}) + NP_BITS'(ad >> 1);
      trial[i] = {rem_r[i][REM_BITS-2:0], lo_r[i][Q_BITS-1]};
      if (res_r[i] > SAT_MAX) begin
        sat_v[i] = SAT_MAX;
      end else if (res_r[i] < SAT_MIN) begin
        sat_v[i] = SAT_MIN;
      end else begin
        sat_v[i] = res_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mac_v_r <= 1'b0;
      mac_c_r <= '0;
      k_r     <= '0;
      c_r     <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      mac_v_r <= (state_r == ST_MAC);
      mac_c_r <= c_r;
      case (state_r)
        ST_IDLE: begin
          k_r <= (cmd_data.basis == BAS_LIN) ? 2'd1 : 2'd0;
          c_r <= '0;
        end
        ST_BASIS: begin
          if (cmd_r.basis == BAS_CR) begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_RTAKE: k_r <= k_r + 2'd1;
        ST_MAC: begin
          c_r <= c_r + 2'd1;
          if (c_r == 2'd3) begin
            k_r <= k_r + 2'd1;
          end
        end
        ST_DIVINIT: dcnt_r <= DIV_LAST;
        ST_DIV:     dcnt_r <= dcnt_r - DCNT_BITS'(1);
        default: ;
      endcase
    end
  end

  // point table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cmd_data.addr[0]] <= cmd_data.pt;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (mac_v_r) begin
      acc_r[mac_c_r] <= acc_r[mac_c_r] + ACC_BITS'(prod_r);
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          cmd_r <= cmd_data;
          for (int i = 0; i < 4; i++) begin
            acc_r[i] <= '0;
          end
          b_r[1] <= BASIS_BITS'(T_ONE) - BASIS_BITS'(cmd_data.u);
          b_r[2] <= BASIS_BITS'(cmd_data.u);
          out_r.status <= (cmd_data.op == OP_BAD) ? STATUS_RANGE : STATUS_DONE;
          out_r.out_x  <= '0;
          out_r.out_y  <= '0;
          out_r.out_z  <= '0;
        end
      end
      ST_ONE: begin
        out_r.status <= STATUS_DONE;
        out_r.out_x  <= rd_r.x;
        out_r.out_y  <= rd_r.y;
        out_r.out_z  <= rd_r.z;
      end
      ST_CUBE: u2_r <= prod_r[U2_BITS-1:0];
      ST_U3:   u3_r <= prod_r[U3_BITS-1:0];
      ST_BASIS: begin
        if (cmd_r.basis == BAS_CR) begin
          b_r[k_r] <= cr_sum[50:33];
        end else begin
          a_r <= bs_sum[50:32];
        end
      end
      ST_RTAKE: b_r[k_r] <= prod_r[41:24];
      ST_ROUND: begin
        for (int i = 0; i < 4; i++) begin
          res_r[i] <= rnd[i];
        end
      end
      ST_DIVINIT: begin
        ad_r <= ad;
        for (int i = 0; i < 3; i++) begin
          ovf_r[i] <= AD_BITS'(np[i][NP_BITS-1:Q_BITS]) >= ad;
          rem_r[i] <= REM_BITS'(np[i][NP_BITS-1:Q_BITS]);
          lo_r[i]  <= np[i][Q_BITS-1:0];
          neg_r[i] <= (res_r[i] < 0) ^ w_neg;
          q_r[i]   <= '0;
        end
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          lo_r[i] <= lo_r[i] << 1;
          if (trial[i] >= REM_BITS'(ad_r)) begin
            rem_r[i] <= trial[i] - REM_BITS'(ad_r);
            q_r[i]   <= {q_r[i][Q_BITS-2:0], 1'b1};
          end else begin
            rem_r[i] <= trial[i];
            q_r[i]   <= {q_r[i][Q_BITS-2:0], 1'b0};
          end
        end
      end
      ST_DIVDONE: begin
        for (int i = 0; i < 3; i++) begin
          if (ovf_r[i]) begin
            res_r[i] <= neg_r[i] ? -RES_BIG : RES_BIG;
          end else begin
            res_r[i] <= neg_r[i] ? -signed'(RES_BITS'(q_r[i])) : signed'(RES_BITS'(q_r[i]));
          end
        end
      end
      ST_SAT: begin
        out_r.status <= STATUS_DONE;
        out_r.out_x  <= sat_v[0][COORD_BITS-1:0];
        out_r.out_y  <= sat_v[1][COORD_BITS-1:0];
        out_r.out_z  <= sat_v[2][COORD_BITS-1:0];
      end
      default: ;
    endcase
  end

  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !cmd_empty) |=> (state_r != ST_IDLE))
    else $error("waiting command not dispatched");

  a_push_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && !res_full) |=> (state_r == ST_IDLE))
    else $error("result transaction did not release the sequencer");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |=> (state_r == ST_DIV || state_r == ST_DIVDONE))
    else $error("divider left before completion");

  a_mac_tag: assert property (@(posedge clk) disable iff (!rst_n)
    mac_v_r |-> ($past(state_r) == ST_MAC))
    else $error("accumulate without a blend product");

  a_div_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVINIT) |-> (res_r[3] != '0))
    else $error("division started with zero weight");

endmodule
